### rtl/rfitb_pkg.sv
package rfitb_pkg;

    localparam int LEN_W = 7;
    localparam int IDX_W = 6;
    localparam int BYTE_W = 8;
    localparam int TMO_W = 16;
    localparam int OP_W = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_BYTE = 2'd0;
    localparam logic [OP_W-1:0] OP_IDLE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK = 2'd2;
    localparam logic [OP_W-1:0] OP_READ = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd1;

    localparam logic [LEN_W-1:0] RST_BUFFER_SIZE = 7'd64;
    localparam logic [TMO_W-1:0] RST_TIMEOUT = 16'd5;
    localparam logic [TMO_W-1:0] SILENCE_MAX = 16'hFFFF;

    // operands for the shared increment/compare unit
    typedef struct packed {
        logic [TMO_W-1:0] a;
        logic [TMO_W-1:0] b;
    } unit_req_t;

    typedef struct packed {
        logic [TMO_W-1:0] sum;  // a + 1
        logic             ge;   // a >= b
        logic             eq;   // a + 1 == b
    } unit_rsp_t;

endpackage

### rtl/rfitb_ram.sv
module rfitb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/rfitb_unit.sv
module rfitb_unit (
    input  rfitb_pkg::unit_req_t req,
    output rfitb_pkg::unit_rsp_t rsp
);

    import rfitb_pkg::*;

    always_comb
    begin
        rsp.sum = req.a + 16'd1;
        rsp.ge  = (req.a >= req.b);
        rsp.eq  = (rsp.sum == req.b);
    end

endmodule

### rtl/rx_frame_idle_timeout_buffer_unit.sv
// Byte, idle and tick beats pass S_EXEC, then S_IDLE; s_tready drops for one cycle after each.
// Read beat: S_EXEC, S_LEN, S_RD, S_LOAD to the first result in S_OUT, then S_RD, S_LOAD, S_OUT
// per further byte (output handshake plus registered frame RAM read), set by the shared
// increment/compare unit and single RAM read port. Not-ready read: one empty result.
// No new input while a read is being delivered. Reset (async, active low) clears fill, done,
// silence count and sequencer; buffer_size resets to 64, timeout_ticks to 5; RAM not cleared.
module rx_frame_idle_timeout_buffer_unit #(
    parameter int BUF_DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [rfitb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rfitb_pkg::TMO_W-1:0]       cfg_data,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // rx_byte[7:0], read_limit[14:8]
    input  logic [1:0]                        s_tuser,   // op[1:0]
    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,   // data[7:0], frame_len[14:8],
                                                         // byte_index[20:15]
    output logic                              m_tlast    // last
);

    import rfitb_pkg::*;

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(BUF_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_LEN  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_LOAD = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [LEN_W-1:0]  limit_reg, limit_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic              done_reg, done_next;
    logic [TMO_W-1:0]  silence_reg, silence_next;
    logic [LEN_W-1:0]  size_reg, size_next;
    logic [TMO_W-1:0]  timeout_reg, timeout_next;
    logic [LEN_W-1:0]  n_reg, n_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [BYTE_W-1:0] dout_reg, dout_next;
    logic              last_reg, last_next;
    logic              deliver_reg, deliver_next;

    logic [LEN_W-1:0]  cap;
    logic              ready;
    unit_req_t         ureq;
    unit_rsp_t         ursp;
    logic              ram_we;
    logic [BYTE_W-1:0] ram_rdata;

    assign cap = (size_reg > DEPTH_LEN) ? DEPTH_LEN : size_reg;

    rfitb_unit u_unit (
        .req (ureq),
        .rsp (ursp)
    );

    assign ram_we = (state_reg == S_EXEC) && (op_reg == OP_BYTE) && !ursp.ge;

    rfitb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUF_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (byte_reg),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // operand select for the shared unit
    always_comb
    begin
        ureq = '0;
        unique case (state_reg)
            S_EXEC:
            begin
                unique case (op_reg)
                    OP_BYTE:
                    begin
                        ureq.a = TMO_W'(fill_reg);
                        ureq.b = TMO_W'(cap);
                    end
                    OP_TICK:
                    begin
                        ureq.a = silence_reg;
                        ureq.b = SILENCE_MAX;
                    end
                    OP_READ:
                    begin
                        ureq.a = silence_reg;
                        ureq.b = timeout_reg;
                    end
                    default:
                    begin
                        ureq = '0;
                    end
                endcase
            end
            S_LEN:
            begin
                ureq.a = TMO_W'(limit_reg);
                ureq.b = TMO_W'(fill_reg);
            end
            S_RD, S_OUT:
            begin
                ureq.a = TMO_W'(idx_reg);
                ureq.b = TMO_W'(n_reg);
            end
            default:
            begin
                ureq = '0;
            end
        endcase
    end

    assign ready = done_reg || ((fill_reg != '0) && ursp.ge);

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        byte_next    = byte_reg;
        limit_next   = limit_reg;
        fill_next    = fill_reg;
        done_next    = done_reg;
        silence_next = silence_reg;
        size_next    = size_reg;
        timeout_next = timeout_reg;
        n_next       = n_reg;
        idx_next     = idx_reg;
        dout_next    = dout_reg;
        last_next    = last_reg;
        deliver_next = deliver_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BUFFER_SIZE: size_next = cfg_data[LEN_W-1:0];
                CFG_TIMEOUT:     timeout_next = cfg_data;
                default:         size_next = size_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tuser;
                    byte_next  = s_tdata[7:0];
                    limit_next = s_tdata[14:8];
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                unique case (op_reg)
                    OP_BYTE:
                    begin
                        if (!ursp.ge)
                        begin
                            fill_next    = ursp.sum[LEN_W-1:0];
                            silence_next = '0;
                        end
                    end
                    OP_IDLE:
                    begin
                        if (fill_reg != '0)
                        begin
                            done_next = 1'b1;
                        end
                    end
                    OP_TICK:
                    begin
                        if (!ursp.ge)
                        begin
                            silence_next = ursp.sum;
                        end
                    end
                    OP_READ:
                    begin
                        if ((limit_reg == '0) || !ready || (fill_reg == '0))
                        begin
                            // empty result, state left alone
                            dout_next    = '0;
                            n_next       = '0;
                            idx_next     = '0;
                            last_next    = 1'b1;
                            deliver_next = 1'b0;
                            state_next   = S_OUT;
                        end
                        else
                        begin
                            deliver_next = 1'b1;
                            idx_next     = '0;
                            state_next   = S_LEN;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_LEN:
            begin
                n_next     = ursp.ge ? fill_reg : limit_reg;
                state_next = S_RD;
            end
            S_RD:
            begin
                last_next  = ursp.eq;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                dout_next  = ram_rdata;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    if (last_reg)
                    begin
                        if (deliver_reg)
                        begin
                            fill_next = '0;
                            done_next = 1'b0;
                        end
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = ursp.sum[IDX_W-1:0];
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            done_reg    <= 1'b0;
            silence_reg <= '0;
            size_reg    <= RST_BUFFER_SIZE;
            timeout_reg <= RST_TIMEOUT;
            deliver_reg <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            done_reg    <= done_next;
            silence_reg <= silence_next;
            size_reg    <= size_next;
            timeout_reg <= timeout_next;
            deliver_reg <= deliver_next;
            last_reg    <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        byte_reg  <= byte_next;
        limit_reg <= limit_next;
        n_reg     <= n_next;
        idx_reg   <= idx_next;
        dout_reg  <= dout_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {3'b000, idx_reg, n_reg, dout_reg};
    assign m_tlast  = last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH_LEN)
        else $error("fill count above store depth");

    a_done_needs_fill: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (fill_reg != '0))
        else $error("frame done with empty store");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && last_reg && deliver_reg) |=> (fill_reg == '0 && !done_reg))
        else $error("frame not cleared after final beat");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && deliver_reg) |-> ((n_reg != '0) && (TMO_W'(idx_reg) < TMO_W'(n_reg))))
        else $error("byte index outside delivered frame");

endmodule
